FILE: hdl/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and codes for the sorted list table.
// Holds the input and result words, the operation and status codes and the
// command and status bundles that pass between the controller and datapath.
// ----------------------------------------------------------------------------
package slt_pkg;

    // Default number of stored values.
    localparam int DEPTH_DEFAULT = 16;

    // Operation codes carried in the input word.
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_SEARCH = 2'd2;

    // Status codes carried in the result word.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Input word.
    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] value;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] found_value;
        logic [4:0]         entry_count;
    } out_word_t;

    // Which entry the memory read port looks at, relative to the index.
    typedef enum logic [1:0] {
        RD_BELOW = 2'd0,
        RD_AT    = 2'd1,
        RD_ABOVE = 2'd2
    } rd_sel_t;

    // Step applied to the index or the count.
    typedef enum logic [1:0] {
        STEP_HOLD = 2'd0,
        STEP_INC  = 2'd1,
        STEP_DEC  = 2'd2
    } step_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;        // capture the value and set the index
        logic       load_top;    // index starts at the count, else at zero
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       wr_en;
        logic       wr_new;      // write the new value, else the word just read
        step_t      idx_step;
        step_t      cnt_step;
        logic       set_result;
        logic [1:0] status;
        logic       set_found;
    } slt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic ge_hit;     // word read is not smaller than the value
        logic eq_hit;     // word read equals the value
        logic idx_one;
        logic idx_last;   // index is the last stored entry
        logic idx_last2;  // index is the last but one stored entry
    } slt_sts_t;

endpackage

FILE: hdl/sorted_list_table.sv
// ----------------------------------------------------------------------------
// sorted_list_table
// Ordered table of up to DEPTH signed 32-bit values.
// Each word inserts a value in ascending order, removes the first equal
// value or searches for one, and yields one result word.
//
//   Channel   Signals                  Handshake
//   --------  -----------------------  ---------------------------------------
//   input     item (func, value)       taken on a clock edge with start high
//                                      and busy low
//   result    result (status,          valid for one cycle while done is high;
//             found_value, entry_count) the receiver cannot stall it
//
// One item is worked on at a time. The read of the value memory is
// registered, so each visited entry takes a read step and then a compare
// or write step, for the scan of an insert, search or remove and for each
// entry that an insert or remove moves. A full, empty or unknown request
// goes straight to its result without touching the memory.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_list_table #(
    parameter int DEPTH = slt_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  slt_pkg::in_word_t  item,
    output logic               done,
    output slt_pkg::out_word_t result
);
    import slt_pkg::*;

    slt_cmd_t cmd;
    slt_sts_t sts;

    // Sequencer.
    slt_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (item.func),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Storage and arithmetic.
    slt_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .value  (item.value),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

endmodule

FILE: hdl/slt_datapath.sv
// ----------------------------------------------------------------------------
// slt_datapath
// Storage, index, count and result registers of the sorted list table.
// The values sit in a single-port-write, single-port-read memory with a
// registered read; the controller steps the index through it.
// ----------------------------------------------------------------------------
module slt_datapath #(
    parameter int DEPTH = slt_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic signed [31:0] value,
    input  slt_pkg::slt_cmd_t cmd,
    output slt_pkg::slt_sts_t sts,
    output slt_pkg::out_word_t result
);
    import slt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]        mem [DEPTH];
    logic signed [31:0] rd_data_reg;
    logic signed [31:0] value_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      idx_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [1:0]         status_reg;
    logic signed [31:0] found_reg;
    logic [CW-1:0]      rd_addr;
    logic [31:0]        wr_data;
    logic [CW+4:0]      count_ext;

    // Read address relative to the index.
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_BELOW: rd_addr = idx_reg - CW'(1);
            RD_ABOVE: rd_addr = idx_reg + CW'(1);
            default:  rd_addr = idx_reg;
        endcase
    end

    assign wr_data = cmd.wr_new ? value_reg : rd_data_reg;

    // Value memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[idx_reg[AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    // The value under operation is held for the whole item.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= value;
        end
    end

    // Index and count updates.
    always_comb
    begin
        if (cmd.load)
        begin
            idx_next = cmd.load_top ? count_reg : '0;
        end
        else
        begin
            unique case (cmd.idx_step)
                STEP_INC: idx_next = idx_reg + CW'(1);
                STEP_DEC: idx_next = idx_reg - CW'(1);
                default:  idx_next = idx_reg;
            endcase
        end

        unique case (cmd.cnt_step)
            STEP_INC: count_next = count_reg + CW'(1);
            STEP_DEC: count_next = count_reg - CW'(1);
            default:  count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

    // Result registers, set once per item by the controller.
    always_ff @(posedge clk)
    begin
        if (cmd.set_result)
        begin
            status_reg <= cmd.status;
            found_reg  <= cmd.set_found ? rd_data_reg : 32'sd0;
        end
    end

    // Status towards the controller.
    always_comb
    begin
        sts.cnt_zero  = (count_reg == '0);
        sts.cnt_full  = (count_reg == CW'(DEPTH));
        sts.ge_hit    = (rd_data_reg >= value_reg);
        sts.eq_hit    = (rd_data_reg == value_reg);
        sts.idx_one   = (idx_reg == CW'(1));
        sts.idx_last  = ((idx_reg + CW'(1)) == count_reg);
        sts.idx_last2 = ((idx_reg + CW'(2)) == count_reg);
    end

    // The reported count wraps at 32 entries.
    assign count_ext = {5'd0, count_reg};

    assign result.status      = status_reg;
    assign result.found_value = found_reg;
    assign result.entry_count = count_ext[4:0];

endmodule

FILE: hdl/slt_controller.sv
// ----------------------------------------------------------------------------
// slt_controller
// Sequencer of the sorted list table.
// Walks the datapath through the scan and shift steps of each operation and
// raises the result strobe for one cycle at the end.
// ----------------------------------------------------------------------------
module slt_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        func,
    input  slt_pkg::slt_sts_t sts,
    output slt_pkg::slt_cmd_t cmd,
    output logic              busy,
    output logic              done
);
    import slt_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_INS_RD   = 10'b00_0000_0010,
        S_INS_CMP  = 10'b00_0000_0100,
        S_PUT      = 10'b00_0000_1000,
        S_FIND_RD  = 10'b00_0001_0000,
        S_FIND_CMP = 10'b00_0010_0000,
        S_SHIFT_RD = 10'b00_0100_0000,
        S_SHIFT_WR = 10'b00_1000_0000,
        S_DEC      = 10'b01_0000_0000,
        S_DONE     = 10'b10_0000_0000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] op_reg;
    logic [1:0] op_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load     = 1'b1;
                    cmd.load_top = (func == FUNC_INSERT);
                    op_next      = func;
                    unique case (func)
                        FUNC_INSERT:
                        begin
                            if (sts.cnt_full)
                            begin
                                cmd.set_result = 1'b1;
                                cmd.status     = ST_FULL;
                                state_next     = S_DONE;
                            end
                            else if (sts.cnt_zero)
                            begin
                                state_next = S_PUT;
                            end
                            else
                            begin
                                state_next = S_INS_RD;
                            end
                        end
                        FUNC_REMOVE, FUNC_SEARCH:
                        begin
                            if (sts.cnt_zero)
                            begin
                                cmd.set_result = 1'b1;
                                cmd.status     = ST_EMPTY;
                                state_next     = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FIND_RD;
                            end
                        end
                        default:
                        begin
                            // An unknown operation changes nothing.
                            cmd.set_result = 1'b1;
                            cmd.status     = ST_OK;
                            state_next     = S_DONE;
                        end
                    endcase
                end
            end

            // Insert scans down from the top, moving words not smaller than the value up by one.
            S_INS_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_BELOW;
                state_next = S_INS_CMP;
            end

            S_INS_CMP:
            begin
                if (sts.ge_hit)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.idx_step = STEP_DEC;
                    state_next   = sts.idx_one ? S_PUT : S_INS_RD;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end

            S_PUT:
            begin
                cmd.wr_en      = 1'b1;
                cmd.wr_new     = 1'b1;
                cmd.cnt_step   = STEP_INC;
                cmd.set_result = 1'b1;
                cmd.status     = ST_OK;
                state_next     = S_DONE;
            end

            // Remove and search scan up from the bottom for an equal word.
            S_FIND_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_AT;
                state_next = S_FIND_CMP;
            end

            S_FIND_CMP:
            begin
                if (sts.eq_hit)
                begin
                    if (op_reg == FUNC_SEARCH)
                    begin
                        cmd.set_result = 1'b1;
                        cmd.status     = ST_OK;
                        cmd.set_found  = 1'b1;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        state_next = sts.idx_last ? S_DEC : S_SHIFT_RD;
                    end
                end
                else if (sts.idx_last)
                begin
                    cmd.set_result = 1'b1;
                    cmd.status     = ST_NOT_FOUND;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.idx_step = STEP_INC;
                    state_next   = S_FIND_RD;
                end
            end

            // Close the gap left by a removed word.
            S_SHIFT_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_ABOVE;
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                cmd.wr_en    = 1'b1;
                cmd.idx_step = STEP_INC;
                state_next   = sts.idx_last2 ? S_DEC : S_SHIFT_RD;
            end

            S_DEC:
            begin
                cmd.cnt_step   = STEP_DEC;
                cmd.set_result = 1'b1;
                cmd.status     = ST_OK;
                state_next     = S_DONE;
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= FUNC_INSERT;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule
